// ===== rtl/psd_pkg.sv =====
// Shared types and constants for the PoE source debounce and ready detector.
// Holds the sample and result word layouts, debounce settings and register indexes.
// No dependencies.
package psd_pkg;

    // Number of equal samples that confirm a new value after the first differing one.
    localparam int unsigned DEBOUNCE_COUNT = 5;
    localparam int unsigned CNT_W = 3;
    localparam logic [CNT_W-1:0] DEB_LIMIT = CNT_W'(DEBOUNCE_COUNT);

    // Configuration register indexes and reset values.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_VBUS_MIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VBUS_HYST = 2'd1;
    localparam logic [15:0] VBUS_MIN_RESET  = 16'd36000;
    localparam logic [15:0] VBUS_HYST_RESET = 16'd1000;

    // Source classification codes.
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_TYPE1 = 2'd1;
    localparam logic [1:0] KIND_TYPE2 = 2'd2;
    localparam logic [1:0] KIND_AUX   = 2'd3;

    // One sample tick.
    typedef struct packed {
        logic        cdb_level;
        logic        t2p_level;
        logic [15:0] vbus_sample_a;
        logic        vbus_fail_a;
        logic [15:0] vbus_sample_b;
        logic        vbus_fail_b;
        logic [15:0] vbus_sample_c;
        logic        vbus_fail_c;
    } sample_word_t;

    // One result word.
    typedef struct packed {
        logic        poe_ok;
        logic        t2p_ok;
        logic        vbus_ok;
        logic [1:0]  source_kind;
        logic        ready_res;
        logic        ready_rose;
        logic        ready_fell;
        logic [15:0] vbus_median_mv;
    } result_word_t;

    // Control for one debouncer: advance on this edge, and whether this is the seeding tick.
    typedef struct packed {
        logic step;
        logic seed;
    } deb_ctl_t;

endpackage

// ===== rtl/psd_debounce.sv =====
// Debouncer for one boolean signal: last sample, saturating count and confirmed value.
// Depends on psd_pkg.
module psd_debounce
    import psd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  deb_ctl_t ctl,
    input  logic     sample,
    output logic     confirmed,
    output logic     confirmed_next
);

    logic             last_reg, last_next;
    logic             conf_reg, conf_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // Next state: a differing sample restarts the count, an equal one raises it to the limit.
    always_comb
    begin
        last_next  = last_reg;
        count_next = count_reg;
        conf_next  = conf_reg;
        if (ctl.seed)
        begin
            last_next = sample;
        end
        else
        begin
            if (sample == last_reg)
            begin
                if (count_reg < DEB_LIMIT)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            else
            begin
                count_next = '0;
                last_next  = sample;
            end
            if (count_next >= DEB_LIMIT)
            begin
                conf_next = sample;
            end
        end
    end

    // State registers, updated only when a word moves to the result stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg  <= 1'b0;
            conf_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (ctl.step)
        begin
            last_reg  <= last_next;
            conf_reg  <= conf_next;
            count_reg <= count_next;
        end
    end

    assign confirmed      = conf_reg;
    assign confirmed_next = conf_next;

endmodule

// ===== rtl/psd_vbus_eval.sv =====
// Median of the three VBUS readings and threshold compare with hysteresis.
// Depends on psd_pkg.
module psd_vbus_eval
    import psd_pkg::*;
(
    input  sample_word_t smp,
    input  logic [15:0]  vbus_thr_mv,
    input  logic [15:0]  vbus_hyst_mv,
    input  logic         ok_now,
    output logic [15:0]  median,
    output logic         over
);

    logic [15:0] a, b, c;
    logic [15:0] lo_ab, hi_ab, lo_hc;
    logic [15:0] thr;

    // A failed reading counts as zero.
    assign a = smp.vbus_fail_a ? 16'd0 : smp.vbus_sample_a;
    assign b = smp.vbus_fail_b ? 16'd0 : smp.vbus_sample_b;
    assign c = smp.vbus_fail_c ? 16'd0 : smp.vbus_sample_c;

    // Median as max(min(a,b), min(max(a,b),c)).
    assign lo_ab  = (a < b) ? a : b;
    assign hi_ab  = (a < b) ? b : a;
    assign lo_hc  = (hi_ab < c) ? hi_ab : c;
    assign median = (lo_ab > lo_hc) ? lo_ab : lo_hc;

    // Lowered threshold while confirmed ok, clamped at zero.
    always_comb
    begin
        thr = vbus_thr_mv;
        if (ok_now)
        begin
            thr = (vbus_hyst_mv > vbus_thr_mv) ? 16'd0 : (vbus_thr_mv - vbus_hyst_mv);
        end
    end

    assign over = (median >= thr);

endmodule

// ===== rtl/poe_source_debounce_ready.sv =====
// Top level of the PoE source debounce and ready detector.
// Depends on psd_pkg, psd_vbus_eval and psd_debounce.
//
// Usage:
//   sample channel (sample_valid, sample_stall, sample) carries one sample tick
//   per word: two pin levels and three VBUS readings with failure flags.
//   result channel (result_valid, result_stall, result) returns exactly one
//   result word per sample word, in order.
//   Configuration: cfg_we with cfg_index 0 writes the VBUS threshold, index 1
//   writes the hysteresis; other indexes are ignored. Write only while idle.
// Timing:
//   A word is taken into an input register, then evaluated and debounced in a
//   single pass into the result register; result_valid rises as it enters it.
//   One word per cycle is sustained while result_stall is low; the debounce
//   state updates in the same cycle that a word enters the result register.
// Reset:
//   All debounce state, the ready flag and the seeding flag clear, registers
//   return to 36000 mV and 1000 mV. The first word after reset only seeds the
//   last-sample registers and reports all confirmations, kind and ready as zero.
// Stalls:
//   While result_stall is high the result word holds; the input register still
//   takes one more word, after which sample_stall rises until the result moves.
module poe_source_debounce_ready
    import psd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  sample_word_t         sample,
    output logic                 result_valid,
    input  logic                 result_stall,
    output result_word_t         result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    logic [15:0]  vbus_min_reg, vbus_hyst_reg;
    logic         in_valid_reg;
    sample_word_t in_word_reg;
    logic         out_valid_reg;
    result_word_t out_word_reg, out_word_next;
    logic         primed_reg;
    logic         ready_reg, ready_next;

    logic         advance;
    logic         take;
    deb_ctl_t     ctl;
    logic [15:0]  median;
    logic         vb_raw;
    logic         vbus_conf;
    logic         cdb_conf_next, t2p_conf_next, vbus_conf_next;
    logic         cdb_conf_unused, t2p_conf_unused;
    logic [1:0]   kind;

    // Handshake: the input stage moves on whenever the result register is free or being taken.
    assign advance      = in_valid_reg && (!out_valid_reg || !result_stall);
    assign sample_stall = in_valid_reg && !advance;
    assign take         = sample_valid && !sample_stall;
    assign ctl.step     = advance;
    assign ctl.seed     = !primed_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vbus_min_reg  <= VBUS_MIN_RESET;
            vbus_hyst_reg <= VBUS_HYST_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VBUS_MIN:  vbus_min_reg  <= cfg_data;
                REG_VBUS_HYST: vbus_hyst_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // VBUS median and threshold.
    psd_vbus_eval u_vbus_eval (
        .smp          (in_word_reg),
        .vbus_thr_mv  (vbus_min_reg),
        .vbus_hyst_mv (vbus_hyst_reg),
        .ok_now       (vbus_conf),
        .median       (median),
        .over         (vb_raw)
    );

    // Debouncers; T2P is active low on the pin.
    psd_debounce u_deb_cdb (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .sample         (in_word_reg.cdb_level),
        .confirmed      (cdb_conf_unused),
        .confirmed_next (cdb_conf_next)
    );

    psd_debounce u_deb_t2p (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .sample         (!in_word_reg.t2p_level),
        .confirmed      (t2p_conf_unused),
        .confirmed_next (t2p_conf_next)
    );

    psd_debounce u_deb_vbus (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .sample         (vb_raw),
        .confirmed      (vbus_conf),
        .confirmed_next (vbus_conf_next)
    );

    // Classification, ready and its edges; the seeding tick reports none.
    always_comb
    begin
        kind       = KIND_NONE;
        ready_next = ready_reg;
        if (primed_reg)
        begin
            priority if (cdb_conf_next)
            begin
                kind = t2p_conf_next ? KIND_TYPE2 : KIND_TYPE1;
            end
            else if (t2p_conf_next)
            begin
                kind = KIND_AUX;
            end
            ready_next = (kind != KIND_NONE) && vbus_conf_next;
        end
        out_word_next.poe_ok         = cdb_conf_next || (cdb_conf_unused && 1'b0);
        out_word_next.t2p_ok         = t2p_conf_next || (t2p_conf_unused && 1'b0);
        out_word_next.vbus_ok        = vbus_conf_next;
        out_word_next.source_kind    = kind;
        out_word_next.ready_res      = primed_reg && ready_next;
        out_word_next.ready_rose     = primed_reg && ready_next && !ready_reg;
        out_word_next.ready_fell     = primed_reg && !ready_next && ready_reg;
        out_word_next.vbus_median_mv = median;
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_word_reg <= sample;
        end
    end

    // Result register and the ready and seeding flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            primed_reg    <= 1'b0;
            ready_reg     <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                primed_reg    <= 1'b1;
                ready_reg     <= ready_next;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_word_reg <= out_word_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_word_reg;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the PoE source debounce and ready detector.
// Drives sample words in bursts against a stalling receiver and checks every result word
// against an in-bench debounce predictor or a typed result. Depends on psd_pkg and the block itself.
module tb_top;
    import psd_pkg::*;

    // Unused register indexes: writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 10;
    localparam int PHASES = 7;

    logic         clk;
    logic         rst_n;
    logic         sample_valid;
    logic         sample_stall;
    sample_word_t sample;
    logic         result_valid;
    logic         result_stall;
    result_word_t result;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;

    poe_source_debounce_ready DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // One queued sample word, optionally with a result typed in by hand.
    typedef struct {
        sample_word_t word;
        bit           typed;
        result_word_t fixed;
    } tick_t;

    // One row of the directed table; fails holds the a, b, c failure flags.
    typedef struct packed {
        logic        cdb;
        logic        t2p;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        logic [2:0]  fails;
        logic [3:0]  reps;
        logic        typed;
        logic [15:0] typed_median;
    } dir_row_t;

    localparam int DIR_ROWS = 8;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // Seeding word straight after reset: everything zero but the median.
        '{1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b000, 4'd1, 1'b1, 16'hFFFF},
        // All three readings failed.
        '{1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b111, 4'd1, 1'b1, 16'd0},
        // Extremes of the readings around a small median.
        '{1'b1, 1'b0, 16'd0, 16'hFFFF, 16'd1, 3'b000, 4'd1, 1'b1, 16'd1},
        // Median exactly on the plain threshold, long enough to confirm type 2.
        '{1'b1, 1'b0, 16'd36000, 16'hFFFF, 16'd36000, 3'b000, 4'd7, 1'b0, 16'd0},
        // Median on the lowered threshold while VBUS is confirmed.
        '{1'b1, 1'b0, 16'hFFFF, 16'd35000, 16'd40000, 3'b100, 4'd4, 1'b0, 16'd0},
        // One below the lowered threshold: ready falls once confirmed.
        '{1'b1, 1'b0, 16'd34999, 16'd5, 16'hFFFF, 3'b010, 4'd6, 1'b0, 16'd0},
        // Pin changes and a failed third reading.
        '{1'b1, 1'b1, 16'hFFFF, 16'd0, 16'h8000, 3'b001, 4'd1, 1'b0, 16'd0},
        '{1'b0, 1'b0, 16'h5555, 16'hAAAA, 16'h7FFF, 3'b000, 4'd2, 1'b0, 16'd0}
    };

    // Debouncer state of one signal.
    typedef struct {
        logic             last;
        logic             confirmed;
        logic [CNT_W-1:0] count;
    } deb_state_t;

    // Predicted block state and register copies.
    deb_state_t  cdb_st;
    deb_state_t  t2p_st;
    deb_state_t  vbus_st;
    logic        primed_st;
    logic        ready_st;
    logic [15:0] min_mv;
    logic [15:0] hyst_mv;

    tick_t        ticks_to_send[$];
    result_word_t pending_results[$];
    int           mismatches;
    int           cycle_count;

    // Sender burst shaping.
    tick_t in_flight;
    int    burst_left;
    int    gap_left;

    // Receiver stall pattern.
    int stall_cycle;
    int stall_mode;

    // Random run shaping: pins and VBUS level held for a run of words.
    int   run_left;
    logic run_cdb;
    logic run_t2p;
    logic run_high;

    function automatic logic [15:0] median3(logic [15:0] a, logic [15:0] b, logic [15:0] c);
        logic [15:0] lo;
        logic [15:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        return (c < lo) ? lo : ((c > hi) ? hi : c);
    endfunction

    // One debouncer step: a differing sample restarts the count, equal samples confirm.
    function automatic deb_state_t deb_next(deb_state_t s, logic smp);
        deb_state_t n;
        n = s;
        if (smp == s.last)
        begin
            if (s.count < DEB_LIMIT)
                n.count = s.count + 1'b1;
        end
        else
        begin
            n.count = '0;
            n.last  = smp;
        end
        if (n.count >= DEB_LIMIT)
            n.confirmed = smp;
        return n;
    endfunction

    // Predicts the result word of one sample word and advances the predicted state.
    task automatic debounce_and_classify(input sample_word_t w, output result_word_t r);
        logic [15:0] ra;
        logic [15:0] rb;
        logic [15:0] rc;
        logic [15:0] med;
        logic [15:0] thr;
        logic        cdb_raw;
        logic        t2p_raw;
        logic        vb_raw;
        ra = w.vbus_fail_a ? 16'd0 : w.vbus_sample_a;
        rb = w.vbus_fail_b ? 16'd0 : w.vbus_sample_b;
        rc = w.vbus_fail_c ? 16'd0 : w.vbus_sample_c;
        med = median3(ra, rb, rc);
        // The threshold drops by the hysteresis once VBUS is confirmed, never below zero.
        if (!vbus_st.confirmed)
            thr = min_mv;
        else
            thr = (hyst_mv > min_mv) ? 16'd0 : min_mv - hyst_mv;
        vb_raw  = (med >= thr);
        cdb_raw = w.cdb_level;
        t2p_raw = ~w.t2p_level;
        r = '0;
        if (!primed_st)
        begin
            cdb_st.last  = cdb_raw;
            t2p_st.last  = t2p_raw;
            vbus_st.last = vb_raw;
            primed_st    = 1'b1;
        end
        else
        begin
            cdb_st  = deb_next(cdb_st, cdb_raw);
            t2p_st  = deb_next(t2p_st, t2p_raw);
            vbus_st = deb_next(vbus_st, vb_raw);
            if (cdb_st.confirmed)
                r.source_kind = t2p_st.confirmed ? KIND_TYPE2 : KIND_TYPE1;
            else if (t2p_st.confirmed)
                r.source_kind = KIND_AUX;
            else
                r.source_kind = KIND_NONE;
            r.ready_res  = (r.source_kind != KIND_NONE) && vbus_st.confirmed;
            r.ready_rose = r.ready_res && !ready_st;
            r.ready_fell = !r.ready_res && ready_st;
            ready_st     = r.ready_res;
        end
        r.poe_ok         = cdb_st.confirmed;
        r.t2p_ok         = t2p_st.confirmed;
        r.vbus_ok        = vbus_st.confirmed;
        r.vbus_median_mv = med;
    endtask

    function automatic void check_field(string name, logic [15:0] exp, logic [15:0] got);
        if (got !== exp)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, exp, got);
            mismatches++;
        end
    endfunction

    function automatic logic [15:0] clamp16(int v);
        if (v < 0)
            return 16'd0;
        if (v > 65535)
            return 16'hFFFF;
        return 16'(v);
    endfunction

    // Queues random words: mostly held runs near the thresholds, some glitches and noise.
    task automatic queue_random(int n);
        tick_t       t;
        logic [63:0] rnd;
        logic [15:0] v [3];
        logic [15:0] tmp;
        int          thr_hi;
        int          thr_lo;
        int          tgt;
        int          j;
        for (int i = 0; i < n; i++)
        begin
            t.typed = 1'b0;
            t.fixed = '0;
            if (run_left == 0)
            begin
                run_left = $urandom_range(1, 14);
                run_cdb  = 1'($urandom_range(0, 1));
                run_t2p  = 1'($urandom_range(0, 1));
                run_high = 1'($urandom_range(0, 1));
            end
            run_left--;
            if ($urandom_range(0, 9) == 0)
            begin
                rnd    = {$urandom, $urandom};
                t.word = rnd[$bits(sample_word_t)-1:0];
            end
            else
            begin
                thr_hi = int'(min_mv);
                thr_lo = (hyst_mv > min_mv) ? 0 : int'(min_mv) - int'(hyst_mv);
                if ($urandom_range(0, 4) == 0)
                    tgt = run_high ? thr_hi : thr_lo - 1;
                else if (run_high)
                    tgt = thr_hi + int'($urandom_range(0, 3000));
                else
                    tgt = thr_lo - int'($urandom_range(1, 3000));
                v[0] = clamp16(tgt);
                v[1] = clamp16(tgt + int'($urandom_range(0, 200)));
                v[2] = 16'($urandom);
                // Shuffle which reading carries which value.
                for (int k = 0; k < 2; k++)
                begin
                    j    = $urandom_range(0, 2);
                    tmp  = v[k];
                    v[k] = v[j];
                    v[j] = tmp;
                end
                t.word.cdb_level     = run_cdb;
                t.word.t2p_level     = run_t2p;
                t.word.vbus_sample_a = v[0];
                t.word.vbus_sample_b = v[1];
                t.word.vbus_sample_c = v[2];
                t.word.vbus_fail_a   = ($urandom_range(0, 11) == 0);
                t.word.vbus_fail_b   = ($urandom_range(0, 11) == 0);
                t.word.vbus_fail_c   = ($urandom_range(0, 11) == 0);
                if ($urandom_range(0, 11) == 0)
                    t.word.cdb_level = ~run_cdb;
                if ($urandom_range(0, 11) == 0)
                    t.word.t2p_level = ~run_t2p;
            end
            ticks_to_send.push_back(t);
        end
    endtask

    // Register writes keep the predictor copy in step with the block.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_VBUS_MIN)
            min_mv = val;
        else if (idx == REG_VBUS_HYST)
            hyst_mv = val;
    endtask

    // Waits until every queued word has gone in and every result word has come back.
    task automatic wait_idle();
        while (ticks_to_send.size() != 0 || sample_valid || pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Sender: words go out in bursts with random gaps; a stalled word holds.
    always @(posedge clk)
    begin
        result_word_t predicted;
        if (rst_n)
        begin
            if (sample_valid && !sample_stall)
            begin
                debounce_and_classify(sample, predicted);
                pending_results.push_back(in_flight.typed ? in_flight.fixed : predicted);
            end
            if (!sample_valid || !sample_stall)
            begin
                if (gap_left == 0 && ticks_to_send.size() != 0)
                begin
                    in_flight = ticks_to_send.pop_front();
                    sample       <= in_flight.word;
                    sample_valid <= 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 20);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    end
                    else
                        burst_left--;
                end
                else
                begin
                    sample_valid <= 1'b0;
                    if (gap_left != 0)
                        gap_left--;
                end
            end
        end
    end

    // Receiver: checks each accepted result word and stalls on a changing pattern.
    always @(posedge clk)
    begin
        result_word_t exp;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result word with nothing expected, got %h", $time, result);
                    mismatches++;
                end
                else
                begin
                    exp = pending_results.pop_front();
                    check_field("poe_ok", 16'(exp.poe_ok), 16'(result.poe_ok));
                    check_field("t2p_ok", 16'(exp.t2p_ok), 16'(result.t2p_ok));
                    check_field("vbus_ok", 16'(exp.vbus_ok), 16'(result.vbus_ok));
                    check_field("source_kind", 16'(exp.source_kind), 16'(result.source_kind));
                    check_field("ready_res", 16'(exp.ready_res), 16'(result.ready_res));
                    check_field("ready_rose", 16'(exp.ready_rose), 16'(result.ready_rose));
                    check_field("ready_fell", 16'(exp.ready_fell), 16'(result.ready_fell));
                    check_field("vbus_median_mv", exp.vbus_median_mv, result.vbus_median_mv);
                end
            end
            stall_cycle++;
            if (stall_cycle % 64 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: result_stall <= 1'b0;
                1: result_stall <= ($urandom_range(0, 3) == 0);
                2: result_stall <= ($urandom_range(0, 3) != 0);
                default: result_stall <= ((stall_cycle % 7) < 3);
            endcase
        end
    end

    // Cycle counter guarding against a hung run.
    initial
    begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge clk);
        $display("FAILURE");
        $finish;
    end

    // Main sequence: reset, directed table, then random phases over several settings.
    initial
    begin
        tick_t t;
        rst_n        <= 1'b0;
        sample_valid <= 1'b0;
        sample       <= '0;
        result_stall <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= REG_VBUS_MIN;
        cfg_data     <= '0;
        cdb_st       = '{1'b0, 1'b0, '0};
        t2p_st       = '{1'b0, 1'b0, '0};
        vbus_st      = '{1'b0, 1'b0, '0};
        primed_st    = 1'b0;
        ready_st     = 1'b0;
        min_mv       = VBUS_MIN_RESET;
        hyst_mv      = VBUS_HYST_RESET;
        mismatches   = 0;
        burst_left   = 0;
        gap_left     = 0;
        stall_cycle  = 0;
        stall_mode   = 0;
        run_left     = 0;
        run_cdb      = 1'b0;
        run_t2p      = 1'b0;
        run_high     = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table, under the reset register values.
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            for (int k = 0; k < int'(DIRECTED[r].reps); k++)
            begin
                t.word.cdb_level     = DIRECTED[r].cdb;
                t.word.t2p_level     = DIRECTED[r].t2p;
                t.word.vbus_sample_a = DIRECTED[r].a;
                t.word.vbus_fail_a   = DIRECTED[r].fails[2];
                t.word.vbus_sample_b = DIRECTED[r].b;
                t.word.vbus_fail_b   = DIRECTED[r].fails[1];
                t.word.vbus_sample_c = DIRECTED[r].c;
                t.word.vbus_fail_c   = DIRECTED[r].fails[0];
                t.typed              = DIRECTED[r].typed;
                t.fixed              = '0;
                t.fixed.vbus_median_mv = DIRECTED[r].typed_median;
                ticks_to_send.push_back(t);
            end
        end
        queue_random(100);
        wait_idle();

        // Random phases: zero thresholds, full scale, hysteresis above the threshold, random settings.
        for (int p = 1; p < PHASES; p++)
        begin
            case (p)
                1:
                begin
                    write_reg(REG_VBUS_MIN, 16'd0);
                    write_reg(REG_VBUS_HYST, 16'd0);
                end
                2:
                begin
                    write_reg(REG_VBUS_MIN, 16'hFFFF);
                    write_reg(REG_VBUS_HYST, 16'd0);
                end
                3:
                begin
                    write_reg(REG_VBUS_MIN, 16'd1000);
                    write_reg(REG_VBUS_HYST, 16'hFFFF);
                end
                4:
                begin
                    write_reg(REG_VBUS_MIN, 16'hFFFF);
                    write_reg(REG_VBUS_HYST, 16'hFFFF);
                end
                5:
                begin
                    write_reg(REG_VBUS_MIN, 16'($urandom));
                    write_reg(REG_VBUS_HYST, 16'($urandom_range(0, 4000)));
                    write_reg(REG_UNUSED_A, 16'($urandom));
                end
                default:
                begin
                    write_reg(REG_VBUS_MIN, 16'($urandom_range(20000, 50000)));
                    write_reg(REG_VBUS_HYST, 16'($urandom));
                    write_reg(REG_UNUSED_B, 16'($urandom));
                end
            endcase
            queue_random(155);
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== poe_source_debounce_ready.f =====
rtl/psd_pkg.sv
rtl/psd_debounce.sv
rtl/psd_vbus_eval.sv
rtl/poe_source_debounce_ready.sv
tb/sv/tb_top.sv
